// File: src/lsof_pkg.sv
// shared types, codes and the pattern table of the line sensor offset filter
`default_nettype none
package lsof_pkg;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_CORNER  = 2'd1,
    CMD_TROUBLE = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_WRITE,
    ST_SUM,
    ST_SUMW,
    ST_MEANGO,
    ST_MEAN,
    ST_TRACK,
    ST_DONE
  } state_t;

  localparam logic [2:0] CFG_AVG_LEN   = 3'd0;
  localparam logic [2:0] CFG_KEEP_SIGN = 3'd1;
  localparam logic [2:0] CFG_STOP_EN   = 3'd2;
  localparam logic [2:0] CFG_HOLD      = 3'd3;
  localparam logic [2:0] CFG_SENSE_EN  = 3'd4;

  localparam logic [4:0] TROUBLE_MAX = 5'd20;

  localparam logic [7:0] PAT_NONE  = 8'h00;
  localparam logic [7:0] PAT_ALL   = 8'hFF;
  localparam logic [7:0] PAT_LOW4  = 8'h0F;
  localparam logic [7:0] PAT_HIGH4 = 8'hF0;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic set_corner;
    logic set_trouble;
    logic filt;
    logic div_start;
    logic div_mean;
    logic wi_ld;
    logic hist_wr;
    logic sum_clr;
    logic rd_en;
    logic mean_ld;
    logic track;
    logic out_ld;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic sensor_en;
    logic stop_en;
    logic div_done;
    logic rd_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic              valid;
    logic signed [3:0] off;
  } pat_t;

  function automatic pat_t pattern_lookup(input logic [7:0] bits);
    pat_t r;
    r.valid = 1'b1;
    r.off   = 4'sd0;
    case (bits)
      8'h01: r.off = 4'sd7;
      8'h02: r.off = 4'sd5;
      8'h03: r.off = 4'sd6;
      8'h04: r.off = 4'sd3;
      8'h06: r.off = 4'sd4;
      8'h08: r.off = 4'sd1;
      8'h0C: r.off = 4'sd2;
      8'h10: r.off = -4'sd1;
      8'h18: r.off = 4'sd0;
      8'h20: r.off = -4'sd3;
      8'h30: r.off = -4'sd2;
      8'h40: r.off = -4'sd5;
      8'h60: r.off = -4'sd4;
      8'hC0: r.off = -4'sd6;
      default: r.valid = 1'b0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/line_sensor_offset_filter.sv
// top level of the line sensor offset filter: controller plus datapath
//
//  channel | ports                          | contents
//  --------+--------------------------------+-------------------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser| tuser cmd; tdata sensor_bits, stop_value,
//          |                                |   worse_value
//  out     | out_tvalid/out_tready/tdata    | filtered_offset, worse_count, corner_flag
//  cfg     | cfg_we/cfg_addr/cfg_wdata      | avg_length, keep_sign, stop_detect_enable,
//          |                                |   hold_count, sensor_enable
//
// one request at a time; a sensing sample reads L ring entries, one per cycle, where L is the
// clamped averaging length, and runs the serial divider of DW bits (7 at depth 16) once for
// the ring index and once for the mean, then a track step with stop detection on.
// commands and samples with sensing off skip the ring and the divider.
// a finished result sits in the output register while the next request is taken;
// a request completes only once that register is free. reset returns the config to its
// defaults, clears the filter state and marks every ring entry as zero.
`default_nettype none
module line_sensor_offset_filter #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // sensor_bits[7:0], stop_value[8], worse_value[13:9]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // filtered_offset[3:0], worse_count[8:4], corner_flag[9]
);
  import lsof_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  lsof_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lsof_datapath #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .stat       (stat),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );
endmodule
`default_nettype wire

// File: src/lsof_div.sv
// restoring divider, one quotient bit per cycle, shared by index wrap and mean
`default_nettype none
module lsof_div #(
  parameter int DW = 8,
  parameter int LW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [LW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quot,
  output logic [LW-1:0]      rem
);
  localparam int CW = (DW > 1) ? $clog2(DW) : 1;

  logic [LW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [LW:0]   trial;
  logic [LW:0]   diff;

  always_comb begin
    trial    = {rem_r, quo_r[DW-1]};
    diff     = trial - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[LW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[LW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

// File: src/lsof_datapath.sv
// datapath: config registers, pattern decode, history ring, sum, mean and track timers
`default_nettype none
module lsof_datapath #(
  parameter int HISTORY_DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lsof_pkg::ctrl_t ctrl,
  output lsof_pkg::stat_t    stat,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_addr,
  input  wire logic [7:0]    cfg_wdata,
  input  wire logic [15:0]   in_tdata,
  input  wire logic [1:0]    in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [15:0]        out_tdata
);
  import lsof_pkg::*;

  localparam int IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int LW0 = $clog2(HISTORY_DEPTH + 1);
  localparam int LW  = (LW0 > 5) ? LW0 : 5;
  localparam int SW  = $clog2(7 * HISTORY_DEPTH + 1);
  localparam int DW  = (SW > LW) ? SW : LW;

  // config
  logic [4:0] avg_len_r;
  logic       keep_sign_r, stop_en_r, sens_en_r;
  logic [7:0] hold_r;

  // current request
  cmd_e       cmd_r;
  logic [7:0] bits_r;
  logic       stop_val_r;
  logic [4:0] worse_val_r;

  // filter state
  logic [IW-1:0]      wi_r;
  logic signed [3:0]  last_off_r;
  logic [4:0]         trouble_r;
  logic signed [3:0]  mean_r;
  logic [7:0]         last_bits_r;
  logic [7:0]         timer_r [3];
  logic [2:0]         held_r;
  logic               corner_r;
  logic signed [3:0]  store_r;

  // history ring
  logic signed [3:0]      hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_r;
  logic signed [3:0]      rd_data_r;
  logic                   rd_ok_r;
  logic                   rd_pend_r;
  logic [IW-1:0]          rd_addr_r;
  logic signed [SW:0]     acc_r;

  // output slot
  logic              out_vld_r;
  logic signed [3:0] out_off_r;
  logic [4:0]        out_worse_r;
  logic              out_corner_r;

  logic [LW-1:0] avg_ext, len_w, len_m1;
  pat_t          pat;
  logic signed [3:0] off_w;
  logic [4:0]    t_inc, t_nxt;
  logic [DW-1:0] wi_inc, dividend;
  logic [SW:0]   mag_w;
  logic          div_done;
  logic [DW-1:0] quot;
  logic [LW-1:0] rem;
  logic [3:0]    q4;
  logic [2:0]    held_nxt;
  logic [7:0]    timer_nxt [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_len_r   <= 5'd1;
      keep_sign_r <= 1'b1;
      stop_en_r   <= 1'b0;
      hold_r      <= 8'd0;
      sens_en_r   <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_AVG_LEN:   avg_len_r   <= cfg_wdata[4:0];
        CFG_KEEP_SIGN: keep_sign_r <= cfg_wdata[0];
        CFG_STOP_EN:   stop_en_r   <= cfg_wdata[0];
        CFG_HOLD:      hold_r      <= cfg_wdata;
        CFG_SENSE_EN:  sens_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // clamp length to 1..HISTORY_DEPTH
  always_comb begin
    avg_ext = LW'(avg_len_r);
    if (avg_len_r == 5'd0) begin
      len_w = LW'(1);
    end else if (avg_ext > LW'(HISTORY_DEPTH)) begin
      len_w = LW'(HISTORY_DEPTH);
    end else begin
      len_w = avg_ext;
    end
    len_m1 = len_w - LW'(1);
  end

  always_comb begin
    pat   = pattern_lookup(bits_r);
    off_w = pat.valid ? pat.off : last_off_r;
    t_inc = (!pat.valid && (trouble_r <= TROUBLE_MAX)) ? trouble_r + 5'd1 : trouble_r;
    if (bits_r inside {PAT_NONE, PAT_ALL, PAT_LOW4, PAT_HIGH4}) begin
      t_nxt = t_inc;
    end else begin
      t_nxt = t_inc >> 1;
    end
  end

  // divider operands
  always_comb begin
    wi_inc   = DW'(wi_r) + DW'(1);
    mag_w    = acc_r[SW] ? -acc_r : acc_r;
    dividend = ctrl.div_mean ? DW'(mag_w[SW-1:0]) : wi_inc;
    q4       = quot[3:0];
  end

  lsof_div #(.DW(DW), .LW(LW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.div_start),
    .dividend (dividend),
    .divisor  (len_w),
    .done     (div_done),
    .quot     (quot),
    .rem      (rem)
  );

  // track hold timers, driven by the stored pattern
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      held_nxt[i]  = held_r[i];
      timer_nxt[i] = timer_r[i];
      if (last_bits_r[5 + i]) begin
        held_nxt[i]  = 1'b1;
        timer_nxt[i] = hold_r;
      end else if (timer_r[i] != 8'd0) begin
        timer_nxt[i] = timer_r[i] - 8'd1;
      end else begin
        held_nxt[i] = 1'b0;
      end
    end
  end

  // request payload and working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r       <= cmd_e'(in_tuser);
      bits_r      <= in_tdata[7:0];
      stop_val_r  <= in_tdata[8];
      worse_val_r <= in_tdata[13:9];
    end
    if (ctrl.filt) begin
      store_r <= keep_sign_r ? off_w : -off_w;
    end
    if (ctrl.hist_wr) begin
      hist_mem[wi_r] <= store_r;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= hist_mem[rd_addr_r];
      rd_ok_r   <= hist_vld_r[rd_addr_r];
    end
    if (ctrl.sum_clr) begin
      rd_addr_r <= '0;
    end else if (ctrl.rd_en) begin
      rd_addr_r <= rd_addr_r + IW'(1);
    end
    if (ctrl.sum_clr) begin
      acc_r <= '0;
    end else if (rd_pend_r && rd_ok_r) begin
      acc_r <= acc_r + (SW+1)'(rd_data_r);
    end
    if (ctrl.out_ld) begin
      out_off_r    <= mean_r;
      out_worse_r  <= trouble_r;
      out_corner_r <= corner_r;
    end
  end

  // filter state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wi_r        <= '0;
      last_off_r  <= 4'sd0;
      trouble_r   <= 5'd0;
      mean_r      <= 4'sd0;
      last_bits_r <= 8'd0;
      held_r      <= 3'b000;
      corner_r    <= 1'b0;
      hist_vld_r  <= '0;
      rd_pend_r   <= 1'b0;
      out_vld_r   <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        timer_r[i] <= 8'd0;
      end
    end else begin
      rd_pend_r <= ctrl.rd_en;
      if (ctrl.filt) begin
        last_bits_r <= bits_r;
        trouble_r   <= t_nxt;
        if (pat.valid) begin
          last_off_r <= pat.off;
        end
      end else if (ctrl.set_trouble) begin
        trouble_r <= worse_val_r;
      end
      if (ctrl.wi_ld) begin
        wi_r <= rem[IW-1:0];
      end
      if (ctrl.hist_wr) begin
        hist_vld_r[wi_r] <= 1'b1;
      end
      if (ctrl.mean_ld) begin
        mean_r <= acc_r[SW] ? -$signed(q4) : $signed(q4);
      end
      if (ctrl.track) begin
        held_r <= held_nxt;
        for (int i = 0; i < 3; i++) begin
          timer_r[i] <= timer_nxt[i];
        end
        if (&held_nxt) begin
          corner_r <= 1'b1;
        end
      end else if (ctrl.set_corner) begin
        corner_r <= stop_val_r;
      end
      if (ctrl.out_ld) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.cmd       = cmd_r;
    stat.sensor_en = sens_en_r;
    stat.stop_en   = stop_en_r;
    stat.div_done  = div_done;
    stat.rd_last   = (rd_addr_r == len_m1[IW-1:0]);
    stat.out_free  = !out_vld_r || out_tready;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_corner_r, out_worse_r, out_off_r};
endmodule
`default_nettype wire

// File: src/lsof_ctrl.sv
// controller state machine sequencing one request through the datapath
`default_nettype none
module lsof_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire lsof_pkg::stat_t stat,
  output lsof_pkg::ctrl_t      ctrl
);
  import lsof_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.cmd)
          CMD_SAMPLE: begin
            if (stat.sensor_en) begin
              ctrl.filt      = 1'b1;
              ctrl.div_start = 1'b1;
              state_nxt      = ST_MOD;
            end else if (stat.stop_en) begin
              state_nxt = ST_TRACK;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          CMD_CORNER: begin
            ctrl.set_corner = 1'b1;
            state_nxt       = ST_DONE;
          end
          CMD_TROUBLE: begin
            ctrl.set_trouble = 1'b1;
            state_nxt        = ST_DONE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_MOD: begin
        // ring index wraps modulo the clamped length
        if (stat.div_done) begin
          ctrl.wi_ld = 1'b1;
          state_nxt  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        ctrl.hist_wr = 1'b1;
        ctrl.sum_clr = 1'b1;
        state_nxt    = ST_SUM;
      end
      ST_SUM: begin
        ctrl.rd_en = 1'b1;
        if (stat.rd_last) begin
          state_nxt = ST_SUMW;
        end
      end
      ST_SUMW: begin
        // last read word is added at this edge
        state_nxt = ST_MEANGO;
      end
      ST_MEANGO: begin
        ctrl.div_start = 1'b1;
        ctrl.div_mean  = 1'b1;
        state_nxt      = ST_MEAN;
      end
      ST_MEAN: begin
        ctrl.div_mean = 1'b1;
        if (stat.div_done) begin
          ctrl.mean_ld = 1'b1;
          state_nxt    = stat.stop_en ? ST_TRACK : ST_DONE;
        end
      end
      ST_TRACK: begin
        ctrl.track = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          ctrl.out_ld = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire
